FILE: src/sri_pkg.sv
// shared constants for the segment versus rectangle edge test
package sri_pkg;

  // default coordinate width in bits, signed
  localparam int unsigned COORD_WIDTH_DEFAULT = 16;

  // legal range of the coordinate width
  localparam int unsigned COORD_WIDTH_MIN = 8;
  localparam int unsigned COORD_WIDTH_MAX = 32;

endpackage

FILE: src/sri_in_if.sv
// request channel: one segment and one rectangle per request
interface sri_in_if import sri_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEFAULT
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] seg_x1;
  logic signed [COORD_WIDTH-1:0] seg_y1;
  logic signed [COORD_WIDTH-1:0] seg_x2;
  logic signed [COORD_WIDTH-1:0] seg_y2;
  logic signed [COORD_WIDTH-1:0] rect_left;
  logic signed [COORD_WIDTH-1:0] rect_top;
  logic        [COORD_WIDTH-2:0] rect_width;
  logic        [COORD_WIDTH-2:0] rect_height;

  modport source (
    output valid, seg_x1, seg_y1, seg_x2, seg_y2,
           rect_left, rect_top, rect_width, rect_height,
    input  ready
  );

  modport sink (
    input  valid, seg_x1, seg_y1, seg_x2, seg_y2,
           rect_left, rect_top, rect_width, rect_height,
    output ready
  );
endinterface

FILE: src/sri_out_if.sv
// result channel: one hit flag per request
interface sri_out_if ();
  logic valid;
  logic ready;
  logic hit;

  modport source (
    output valid, hit,
    input  ready
  );

  modport sink (
    input  valid, hit,
    output ready
  );
endinterface

FILE: src/sri_edge_chk.sv
// exact parametric crossing check for one rectangle edge, no division
module sri_edge_chk #(
  parameter int unsigned NUM_WIDTH = 36
) (
  input  logic signed [NUM_WIDTH-1:0] den_i,
  input  logic signed [NUM_WIDTH-1:0] tn_i,
  input  logic signed [NUM_WIDTH-1:0] un_i,
  output logic                        hit_o
);

  logic den_nz;
  logic den_pos;
  logic t_ok;
  logic u_ok;

  assign den_nz  = (den_i != '0);
  assign den_pos = ~den_i[NUM_WIDTH-1];

  // 0 <= n/den <= 1 without dividing: bound n by zero and den on the side of den's sign
  always_comb begin
    if (den_pos) begin
      t_ok = ~tn_i[NUM_WIDTH-1] && (tn_i <= den_i);
      u_ok = ~un_i[NUM_WIDTH-1] && (un_i <= den_i);
    end else begin
      t_ok = (tn_i[NUM_WIDTH-1] || (tn_i == '0)) && (tn_i >= den_i);
      u_ok = (un_i[NUM_WIDTH-1] || (un_i == '0)) && (un_i >= den_i);
    end
  end

  assign hit_o = den_nz && t_ok && u_ok;

endmodule

FILE: src/segment_rect_intersect.sv
// Segment versus axis-aligned rectangle edge test. One request (a segment and a
// rectangle given as left, top, width and height) is taken every cycle and the hit
// flag is formed in these registered steps: operand differences, then a bank of ten
// parallel multipliers, then numerator assembly, then the sign and magnitude
// checks of all four rectangle sides into the output register. The multiplier stage sets
// the clock; throughput is one request per cycle whenever the result side takes
// results. A stalled output holds the whole pipeline, nothing is lost or repeated.
// The edges are exact: right and bottom are formed at full precision, a parallel
// or zero-length edge never hits, and touching an edge counts as a hit.
module segment_rect_intersect import sri_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  sri_in_if.sink        seg_i,
  sri_out_if.source     res_o
);

  localparam int unsigned CW = COORD_WIDTH;
  // operand width: one coordinate minus an extended edge
  localparam int unsigned OW = CW + 2;
  // product and numerator width
  localparam int unsigned NW = 2 * OW;

  logic adv;

  // stage 1: operand differences
  logic signed [OW-1:0] x1_e, y1_e, x2_e, y2_e, l_e, t_e, w_e, h_e, r_e, b_e;
  logic signed [OW-1:0] dx_d, dy_d, xl_d, yt_d, yb_d, xr_d;
  logic signed [OW-1:0] dx_q, dy_q, xl_q, yt_q, yb_q, xr_q, w_q, h_q;
  logic                 v1_q;

  // stage 2: products
  logic signed [NW-1:0] den_tb_d, den_lr_d, tn_t_d, tn_b_d, tn_l_d, tn_r_d;
  logic signed [NW-1:0] pa_d, pb_d, pc_d, pd_d;
  logic signed [NW-1:0] den_tb_q, den_lr_q, tn_t_q, tn_b_q, tn_l_q, tn_r_q;
  logic signed [NW-1:0] pa_q, pb_q, pc_q, pd_q;
  logic                 v2_q;

  // stage 3: per-edge numerators and denominators
  logic signed [NW-1:0] e_den_tb_q, e_den_lr_q;
  logic signed [NW-1:0] e_tn_t_q, e_tn_b_q, e_tn_l_q, e_tn_r_q;
  logic signed [NW-1:0] e_un_tl_q, e_un_b_q, e_un_r_q;
  logic                 v3_q;

  // stage 4: output register
  logic hit_top, hit_left, hit_right, hit_bot;
  logic hit_q;
  logic v4_q;

  assign adv         = ~v4_q || res_o.ready;
  assign seg_i.ready = adv;

  assign x1_e = {{2{seg_i.seg_x1[CW-1]}}, seg_i.seg_x1};
  assign y1_e = {{2{seg_i.seg_y1[CW-1]}}, seg_i.seg_y1};
  assign x2_e = {{2{seg_i.seg_x2[CW-1]}}, seg_i.seg_x2};
  assign y2_e = {{2{seg_i.seg_y2[CW-1]}}, seg_i.seg_y2};
  assign l_e  = {{2{seg_i.rect_left[CW-1]}}, seg_i.rect_left};
  assign t_e  = {{2{seg_i.rect_top[CW-1]}}, seg_i.rect_top};
  assign w_e  = {3'b000, seg_i.rect_width};
  assign h_e  = {3'b000, seg_i.rect_height};
  assign r_e  = l_e + w_e;
  assign b_e  = t_e + h_e;

  assign dx_d = x1_e - x2_e;
  assign dy_d = y1_e - y2_e;
  assign xl_d = x1_e - l_e;
  assign yt_d = y1_e - t_e;
  assign yb_d = y1_e - b_e;
  assign xr_d = x1_e - r_e;

  // top and bottom share den = dy*w, left and right share den = -dx*h
  assign den_tb_d = dy_q * w_q;
  assign den_lr_d = dx_q * h_q;
  assign tn_t_d   = yt_q * w_q;
  assign tn_b_d   = yb_q * w_q;
  assign tn_l_d   = xl_q * h_q;
  assign tn_r_d   = xr_q * h_q;
  // cross terms of the second numerator
  assign pa_d     = xl_q * dy_q;
  assign pb_d     = yt_q * dx_q;
  assign pc_d     = yb_q * dx_q;
  assign pd_d     = xr_q * dy_q;

  sri_edge_chk #(.NUM_WIDTH(NW)) u_chk_top (
    .den_i (e_den_tb_q),
    .tn_i  (e_tn_t_q),
    .un_i  (e_un_tl_q),
    .hit_o (hit_top)
  );

  sri_edge_chk #(.NUM_WIDTH(NW)) u_chk_left (
    .den_i (e_den_lr_q),
    .tn_i  (e_tn_l_q),
    .un_i  (e_un_tl_q),
    .hit_o (hit_left)
  );

  sri_edge_chk #(.NUM_WIDTH(NW)) u_chk_right (
    .den_i (e_den_lr_q),
    .tn_i  (e_tn_r_q),
    .un_i  (e_un_r_q),
    .hit_o (hit_right)
  );

  sri_edge_chk #(.NUM_WIDTH(NW)) u_chk_bot (
    .den_i (e_den_tb_q),
    .tn_i  (e_tn_b_q),
    .un_i  (e_un_b_q),
    .hit_o (hit_bot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= seg_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
      xl_q <= xl_d;
      yt_q <= yt_d;
      yb_q <= yb_d;
      xr_q <= xr_d;
      w_q  <= w_e;
      h_q  <= h_e;

      den_tb_q <= den_tb_d;
      den_lr_q <= den_lr_d;
      tn_t_q   <= tn_t_d;
      tn_b_q   <= tn_b_d;
      tn_l_q   <= tn_l_d;
      tn_r_q   <= tn_r_d;
      pa_q     <= pa_d;
      pb_q     <= pb_d;
      pc_q     <= pc_d;
      pd_q     <= pd_d;

      // vertical edges carry a negated den and first numerator
      e_den_tb_q <= den_tb_q;
      e_den_lr_q <= -den_lr_q;
      e_tn_t_q   <= tn_t_q;
      e_tn_b_q   <= tn_b_q;
      e_tn_l_q   <= -tn_l_q;
      e_tn_r_q   <= -tn_r_q;
      e_un_tl_q  <= pa_q - pb_q;
      e_un_b_q   <= pa_q - pc_q;
      e_un_r_q   <= pd_q - pb_q;

      hit_q <= hit_top | hit_left | hit_right | hit_bot;
    end
  end

  assign res_o.valid = v4_q;
  assign res_o.hit   = hit_q;

endmodule

FILE: sim/sri_checker.sv
// watches both channels of segment_rect_intersect, predicts each hit flag and compares
module sri_checker import sri_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sri_in_if           seg_i,
  sri_out_if          res_i,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o
);

  // wide enough for edges past the coordinate range and for every cross product
  localparam int unsigned WW = 2 * COORD_WIDTH + 8;
  typedef logic signed [WW-1:0] wide_t;

  bit          hit_expect_q[$];
  int unsigned fail_cnt = 0;

  function automatic bit edge_crossed(input wide_t x1, input wide_t y1,
                                      input wide_t x2, input wide_t y2,
                                      input wide_t x3, input wide_t y3,
                                      input wide_t x4, input wide_t y4);
    wide_t den;
    wide_t tn;
    wide_t un;
    den = (x1 - x2) * (y3 - y4) - (y1 - y2) * (x3 - x4);
    // parallel or zero-length lines never hit
    if (den == 0) return 1'b0;
    tn = (x1 - x3) * (y3 - y4) - (y1 - y3) * (x3 - x4);
    un = (x1 - x3) * (y1 - y2) - (y1 - y3) * (x1 - x2);
    // both parameters in [0,1], bounds inclusive
    if (den > 0) return tn >= 0 && tn <= den && un >= 0 && un <= den;
    return tn <= 0 && tn >= den && un <= 0 && un >= den;
  endfunction

  function automatic bit predict_hit(
    input logic signed [COORD_WIDTH-1:0] x1, input logic signed [COORD_WIDTH-1:0] y1,
    input logic signed [COORD_WIDTH-1:0] x2, input logic signed [COORD_WIDTH-1:0] y2,
    input logic signed [COORD_WIDTH-1:0] left, input logic signed [COORD_WIDTH-1:0] top,
    input logic [COORD_WIDTH-2:0] w, input logic [COORD_WIDTH-2:0] h);
    wide_t ax1, ay1, ax2, ay2, al, at, ar, ab, aw, ah;
    ax1 = x1;
    ay1 = y1;
    ax2 = x2;
    ay2 = y2;
    al  = left;
    at  = top;
    aw  = w;
    ah  = h;
    ar  = al + aw;
    ab  = at + ah;
    return edge_crossed(ax1, ay1, ax2, ay2, al, at, ar, at) ||
           edge_crossed(ax1, ay1, ax2, ay2, al, at, al, ab) ||
           edge_crossed(ax1, ay1, ax2, ay2, ar, at, ar, ab) ||
           edge_crossed(ax1, ay1, ax2, ay2, al, ab, ar, ab);
  endfunction

  task automatic report_mismatch(input string what);
    if (fail_cnt < 200) $display("[%0t] hit check: %s", $time, what);
    fail_cnt++;
  endtask

  always @(posedge clk_i) begin : watch
    bit want;
    if (rst_ni) begin
      // retire first so a request and a result on the same edge never pair up
      if (res_i.valid && res_i.ready) begin
        if (hit_expect_q.size() == 0) begin
          report_mismatch("result with no request pending");
        end else begin
          want = hit_expect_q.pop_front();
          if (res_i.hit !== want)
            report_mismatch($sformatf("hit got %b, want %b", res_i.hit, want));
        end
      end
      if (seg_i.valid && seg_i.ready) begin
        hit_expect_q.push_back(predict_hit(seg_i.seg_x1, seg_i.seg_y1,
                                           seg_i.seg_x2, seg_i.seg_y2,
                                           seg_i.rect_left, seg_i.rect_top,
                                           seg_i.rect_width, seg_i.rect_height));
      end
    end
    fail_cnt_o <= fail_cnt;
    pending_o  <= hit_expect_q.size();
  end

endmodule

FILE: sim/tb.sv
// top of the segment_rect_intersect testbench: clock, reset, request stimulus and verdict
module tb;
  import sri_pkg::*;

  localparam int unsigned CW       = COORD_WIDTH_DEFAULT;
  localparam int          SMAX     = 2 ** (CW - 1) - 1;
  localparam int          SMIN     = -(2 ** (CW - 1));
  localparam int          UMAX     = 2 ** (CW - 1) - 1;
  localparam int          N_RANDOM = 1550;
  localparam int unsigned LIMIT    = 200000;

  typedef struct packed {
    logic signed [CW-1:0] x1;
    logic signed [CW-1:0] y1;
    logic signed [CW-1:0] x2;
    logic signed [CW-1:0] y2;
    logic signed [CW-1:0] left;
    logic signed [CW-1:0] top;
    logic        [CW-2:0] w;
    logic        [CW-2:0] h;
  } seg_rect_t;

  logic        clk;
  logic        rst_n;
  bit          quiet = 1'b0;
  int unsigned fail_cnt;
  int unsigned pending;
  int unsigned cycle_cnt = 0;

  sri_in_if #(.COORD_WIDTH(CW)) seg_ch ();
  sri_out_if                    res_ch ();

  segment_rect_intersect #(.COORD_WIDTH(CW)) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .seg_i  (seg_ch),
    .res_o  (res_ch)
  );

  sri_checker #(.COORD_WIDTH(CW)) chk (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .seg_i      (seg_ch),
    .res_i      (res_ch),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("segment_rect_intersect verification failed");
      $finish;
    end
  end

  // result side stalls at random, except in the quiet stretch
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res_ch.ready <= quiet || ($urandom_range(99) >= 30);
    end
  end

  function automatic seg_rect_t mk(input int x1, input int y1, input int x2, input int y2,
                                   input int l, input int t, input int w, input int h);
    seg_rect_t r;
    r.x1   = CW'(x1);
    r.y1   = CW'(y1);
    r.x2   = CW'(x2);
    r.y2   = CW'(y2);
    r.left = CW'(l);
    r.top  = CW'(t);
    r.w    = (CW-1)'(w);
    r.h    = (CW-1)'(h);
    return r;
  endfunction

  function automatic int extreme_coord();
    case ($urandom_range(6))
      0: return SMIN;
      1: return SMIN + 1;
      2: return -1;
      3: return 0;
      4: return 1;
      5: return SMAX - 1;
      default: return SMAX;
    endcase
  endfunction

  // a coordinate on, just beside, or between the edges of one axis
  function automatic int snap_coord(input int lo, input int span);
    int c;
    case ($urandom_range(4))
      0: c = lo;
      1: c = lo + span;
      2: c = lo + $urandom_range(0, span);
      3: c = lo - $urandom_range(1, 40);
      default: c = lo + span + $urandom_range(1, 40);
    endcase
    if ($urandom_range(3) == 0) c = c + $urandom_range(0, 2) - 1;
    return c;
  endfunction

  function automatic int rand_extent();
    case ($urandom_range(9))
      0: return 0;
      1: return $urandom_range(0, UMAX);
      default: return $urandom_range(1, 200);
    endcase
  endfunction

  function automatic seg_rect_t rand_req();
    seg_rect_t r;
    int sel, l, t, w, h;
    sel = $urandom_range(99);
    if (sel < 25) begin
      r.x1   = CW'($urandom);
      r.y1   = CW'($urandom);
      r.x2   = CW'($urandom);
      r.y2   = CW'($urandom);
      r.left = CW'($urandom);
      r.top  = CW'($urandom);
      r.w    = (CW-1)'($urandom);
      r.h    = (CW-1)'($urandom);
    end else if (sel < 88) begin
      l = $urandom_range(0, 2 * SMAX) + SMIN;
      t = $urandom_range(0, 2 * SMAX) + SMIN;
      w = rand_extent();
      h = rand_extent();
      if (sel < 55) begin
        // endpoints scattered around the rectangle
        r = mk(l + $urandom_range(0, w + 120) - 60, t + $urandom_range(0, h + 120) - 60,
               l + $urandom_range(0, w + 120) - 60, t + $urandom_range(0, h + 120) - 60,
               l, t, w, h);
      end else begin
        // endpoints snapped to edges and corners
        r = mk(snap_coord(l, w), snap_coord(t, h), snap_coord(l, w), snap_coord(t, h),
               l, t, w, h);
      end
    end else begin
      r = mk(extreme_coord(), extreme_coord(), extreme_coord(), extreme_coord(),
             extreme_coord(), extreme_coord(),
             ($urandom_range(1) != 0) ? $urandom_range(0, 1) : UMAX - $urandom_range(0, 1),
             ($urandom_range(1) != 0) ? $urandom_range(0, 1) : UMAX - $urandom_range(0, 1));
    end
    return r;
  endfunction

  task automatic send_req(input seg_rect_t r);
    while (!quiet && $urandom_range(99) < 30) begin
      seg_ch.valid <= 1'b0;
      @(posedge clk);
    end
    seg_ch.valid       <= 1'b1;
    seg_ch.seg_x1      <= r.x1;
    seg_ch.seg_y1      <= r.y1;
    seg_ch.seg_x2      <= r.x2;
    seg_ch.seg_y2      <= r.y2;
    seg_ch.rect_left   <= r.left;
    seg_ch.rect_top    <= r.top;
    seg_ch.rect_width  <= r.w;
    seg_ch.rect_height <= r.h;
    @(posedge clk);
    while (!seg_ch.ready) @(posedge clk);
  endtask

  // hold requests off until every hit flag is back
  task automatic drain_results();
    seg_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    rst_n              <= 1'b0;
    seg_ch.valid       <= 1'b0;
    seg_ch.seg_x1      <= '0;
    seg_ch.seg_y1      <= '0;
    seg_ch.seg_x2      <= '0;
    seg_ch.seg_y2      <= '0;
    seg_ch.rect_left   <= '0;
    seg_ch.rect_top    <= '0;
    seg_ch.rect_width  <= '0;
    seg_ch.rect_height <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // crossings of each edge, inside, outside, touching
    send_req(mk(50, -50, 50, 50, 0, 0, 100, 100));
    send_req(mk(-50, 50, 50, 50, 0, 0, 100, 100));
    send_req(mk(150, 50, 50, 50, 0, 0, 100, 100));
    send_req(mk(50, 150, 50, 50, 0, 0, 100, 100));
    send_req(mk(10, 10, 20, 20, 0, 0, 100, 100));
    send_req(mk(200, 200, 300, 300, 0, 0, 100, 100));
    send_req(mk(50, -50, 50, 0, 0, 0, 100, 100));
    send_req(mk(-10, -10, 0, 0, 0, 0, 100, 100));
    send_req(mk(-10, -10, -1, -1, 0, 0, 100, 100));
    // degenerate edges and segments, collinear and parallel
    send_req(mk(-10, 50, 10, 50, 0, 0, 0, 100));
    send_req(mk(50, -10, 50, 10, 0, 0, 100, 0));
    send_req(mk(-10, -10, 10, 10, 5, 5, 0, 0));
    send_req(mk(50, 0, 50, 0, 0, 0, 100, 100));
    send_req(mk(-10, 0, 110, 0, 0, 0, 100, 100));
    send_req(mk(110, -10, 110, 200, 0, 0, 100, 100));
    // extremes, edges beyond the coordinate range
    send_req(mk(SMIN, SMIN, SMAX, SMAX, SMAX, SMAX, UMAX, UMAX));
    send_req(mk(SMIN, SMAX, SMAX, SMIN, SMIN, SMIN, UMAX, UMAX));
    send_req(mk(SMAX, 0, SMAX, 100, SMAX - 100, 0, UMAX, 50));
    send_req(mk(SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, 0, 0));
    send_req(mk(SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, UMAX, UMAX));
    send_req(mk(SMIN, 0, SMAX, 0, SMIN, SMIN, UMAX, UMAX));
    send_req(mk(0, SMIN, 0, SMAX, -1, -1, 1, 1));
    send_req(mk(-1, -1, -1, -1, -1, -1, UMAX, UMAX));
    drain_results();

    for (int i = 0; i < N_RANDOM; i++) begin
      quiet = (i >= 700 && i < 1000);
      if (i == 400) drain_results();
      send_req(rand_req());
    end
    quiet = 1'b0;
    drain_results();
    repeat (10) @(posedge clk);

    if (fail_cnt == 0 && pending == 0) begin
      $display("segment_rect_intersect verification clean");
    end else begin
      $display("segment_rect_intersect verification failed");
    end
    $finish;
  end

endmodule
